FILE: sv/hsq_pkg.sv
// ----------------------------------------------------------------------------
// Homing sequencer package
// Widths, register map, sequencer stage codes and the structs that pass
// between the axis lanes, the merge logic and the top level.
// ----------------------------------------------------------------------------
package hsq_pkg;

   localparam int AXES        = 3;
   localparam int ANGLE_WIDTH = 24;
   localparam int POS_W       = 24;
   localparam int ERR_W       = 32;
   localparam int STEP_W      = 16;
   localparam int BOFF_W      = 23;
   localparam int TOL_W       = 16;
   localparam int SETTLE_W    = 16;
   localparam int GEAR_W      = 16;
   localparam int SW_W        = 3;
   localparam int PHASE_W     = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int GEAR_FRAC   = 8;

   localparam logic [STEP_W-1:0]   COARSE_STEP_RST   = 16'd29;
   localparam logic [STEP_W-1:0]   FINE_STEP_RST     = 16'd6;
   localparam logic [BOFF_W-1:0]   BACKOFF_ANGLE_RST = 23'd5719;
   localparam logic [TOL_W-1:0]    BACKOFF_TOL_RST   = 16'd572;
   localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST  = 16'd1000;
   localparam logic [GEAR_W-1:0]   GEAR_RATIO_RST    = 16'd256;

   typedef enum logic [2:0] {
      REG_COARSE_STEP   = 3'd0,
      REG_FINE_STEP     = 3'd1,
      REG_BACKOFF_ANGLE = 3'd2,
      REG_BACKOFF_TOL   = 3'd3,
      REG_SETTLE_TICKS  = 3'd4,
      REG_GEAR_RATIO    = 3'd5
   } csr_reg_type;

   typedef enum logic [PHASE_W-1:0] {
      ST_IDLE    = 3'd0,
      ST_COARSE  = 3'd1,
      ST_BACKOFF = 3'd2,
      ST_FINE    = 3'd3,
      ST_DONE    = 3'd4
   } stage_type;

   typedef struct packed {
      logic coarse_found;
      logic at_backoff;
      logic fine_found;
   } lane_flags_type;

   typedef struct packed {
      stage_type             stage;
      logic [SETTLE_W-1:0]   settle_count;
      logic                  offset_pending;
   } seq_state_type;

   typedef struct packed {
      logic                drive_valid;
      logic [SW_W-1:0]     clear_encoders;
      logic                enable_motors;
      logic                offset_request;
      logic [PHASE_W-1:0]  phase;
      logic                homed;
   } out_ctrl_type;

endpackage

FILE: sv/hsq_req_if.sv
// ----------------------------------------------------------------------------
// Homing sequencer request channel
// Valid/ready channel carrying one control tick: arm angles, switches and
// handshake inputs.
// ----------------------------------------------------------------------------
interface hsq_req_if;
   import hsq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] position_a;
   logic signed [POS_W-1:0] position_b;
   logic signed [POS_W-1:0] position_c;
   logic [SW_W-1:0]         home_switches;
   logic                    offset_done;
   logic                    restart;

   modport source (
      output valid, position_a, position_b, position_c, home_switches,
             offset_done, restart,
      input  ready
   );

   modport sink (
      input  valid, position_a, position_b, position_c, home_switches,
             offset_done, restart,
      output ready
   );

endinterface

FILE: sv/hsq_rsp_if.sv
// ----------------------------------------------------------------------------
// Homing sequencer result channel
// Valid/ready channel carrying the scaled errors and the sequencer outputs.
// ----------------------------------------------------------------------------
interface hsq_rsp_if;
   import hsq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ERR_W-1:0] error_a;
   logic signed [ERR_W-1:0] error_b;
   logic signed [ERR_W-1:0] error_c;
   logic                    drive_valid;
   logic [SW_W-1:0]         clear_encoders;
   logic                    enable_motors;
   logic                    offset_request;
   logic [PHASE_W-1:0]      phase;
   logic                    homed;

   modport source (
      output valid, error_a, error_b, error_c, drive_valid, clear_encoders,
             enable_motors, offset_request, phase, homed,
      input  ready
   );

   modport sink (
      input  valid, error_a, error_b, error_c, drive_valid, clear_encoders,
             enable_motors, offset_request, phase, homed,
      output ready
   );

endinterface

FILE: sv/hsq_lane.sv
// ----------------------------------------------------------------------------
// Homing sequencer axis lane
// Per-axis target ramping, switch detection and backoff check for one tick,
// producing the next target, the next axis flags and the error difference.
// ----------------------------------------------------------------------------
module hsq_lane #(
   parameter int ANGLE_WIDTH = hsq_pkg::ANGLE_WIDTH
) (
   input  hsq_pkg::stage_type                 stage,
   input  logic signed [ANGLE_WIDTH-1:0]      target,
   input  hsq_pkg::lane_flags_type            flags,
   input  logic signed [hsq_pkg::POS_W-1:0]   position,
   input  logic                               home_switch,
   input  logic [hsq_pkg::STEP_W-1:0]         coarse_step,
   input  logic [hsq_pkg::STEP_W-1:0]         fine_step,
   input  logic [hsq_pkg::BOFF_W-1:0]         backoff_angle,
   input  logic [hsq_pkg::TOL_W-1:0]          backoff_tolerance,
   output logic signed [ANGLE_WIDTH-1:0]      target_in,
   output hsq_pkg::lane_flags_type            flags_in,
   output logic                               clear_encoder,
   output logic signed [((ANGLE_WIDTH > hsq_pkg::POS_W) ? ANGLE_WIDTH : hsq_pkg::POS_W):0]
                                              diff
);
   import hsq_pkg::*;

   localparam int BASE_W = (ANGLE_WIDTH > POS_W) ? ANGLE_WIDTH : POS_W;
   localparam int LW     = BASE_W + 2;
   localparam int DW     = BASE_W + 1;
   localparam logic signed [LW-1:0] ANG_MAX =
      {{(LW-ANGLE_WIDTH+1){1'b0}}, {(ANGLE_WIDTH-1){1'b1}}};
   localparam logic signed [LW-1:0] ANG_MIN =
      {{(LW-ANGLE_WIDTH+1){1'b1}}, {(ANGLE_WIDTH-1){1'b0}}};

   logic signed [LW-1:0] tgt_w;
   logic signed [LW-1:0] pos_w;
   logic signed [LW-1:0] boff_w;
   logic signed [LW-1:0] goal;
   logic signed [LW-1:0] fine_w;
   logic signed [LW-1:0] down_step;
   logic signed [LW-1:0] tol_w;
   logic signed [LW-1:0] rdiff;
   logic signed [LW-1:0] rmag;
   logic signed [LW-1:0] ramp_t;
   logic signed [LW-1:0] down_raw;
   logic signed [LW-1:0] down_t;
   logic signed [LW-1:0] bdev;
   logic signed [LW-1:0] babs;
   logic signed [LW-1:0] tgt_n;
   logic signed [LW-1:0] pos_eff;
   logic signed [LW-1:0] diff_w;
   logic                 reached;
   logic                 in_tol;

   always_comb begin
      tgt_w     = {{(LW-ANGLE_WIDTH){target[ANGLE_WIDTH-1]}}, target};
      pos_w     = {{(LW-POS_W){position[POS_W-1]}}, position};
      boff_w    = {{(LW-BOFF_W){1'b0}}, backoff_angle};
      fine_w    = {{(LW-STEP_W){1'b0}}, fine_step};
      tol_w     = {{(LW-TOL_W){1'b0}}, backoff_tolerance};
      down_step = (stage == ST_COARSE) ? {{(LW-STEP_W){1'b0}}, coarse_step} : fine_w;
      goal      = (boff_w > ANG_MAX) ? ANG_MAX : boff_w;
      rdiff     = goal - tgt_w;
      rmag      = (rdiff < 0) ? -rdiff : rdiff;
      reached   = rmag <= fine_w;
      if (reached) begin
         ramp_t = goal;
      end else if (rdiff > 0) begin
         ramp_t = tgt_w + fine_w;
      end else begin
         ramp_t = tgt_w - fine_w;
      end
      down_raw  = tgt_w - down_step;
      down_t    = (down_raw < ANG_MIN) ? ANG_MIN : down_raw;
      bdev      = pos_w - boff_w;
      babs      = (bdev < 0) ? -bdev : bdev;
      in_tol    = babs <= tol_w;
   end

   always_comb begin
      tgt_n         = tgt_w;
      flags_in      = flags;
      clear_encoder = 1'b0;
      pos_eff       = pos_w;
      case (stage)
         ST_IDLE: begin
            tgt_n    = '0;
            flags_in = '0;
            pos_eff  = '0;
         end
         ST_COARSE: begin
            if (flags.coarse_found) begin
               tgt_n = ramp_t;
            end else if (home_switch) begin
               clear_encoder         = 1'b1;
               flags_in.coarse_found = 1'b1;
               tgt_n                 = '0;
               pos_eff               = '0;
            end else begin
               tgt_n = down_t;
            end
         end
         ST_BACKOFF: begin
            tgt_n = ramp_t;
            if (reached) begin
               flags_in.at_backoff = in_tol;
            end
         end
         ST_FINE: begin
            if (home_switch && !flags.fine_found) begin
               clear_encoder       = 1'b1;
               flags_in.fine_found = 1'b1;
               tgt_n               = '0;
               pos_eff             = '0;
            end else if (flags.fine_found) begin
               tgt_n = '0;
            end else begin
               tgt_n = down_t;
            end
         end
         default: begin
            tgt_n    = '0;
            flags_in = '0;
         end
      endcase
      diff_w    = tgt_n - pos_eff;
      diff      = diff_w[DW-1:0];
      target_in = tgt_n[ANGLE_WIDTH-1:0];
   end

endmodule

FILE: sv/hsq_merge.sv
// ----------------------------------------------------------------------------
// Homing sequencer merge logic
// Combines the lane results into the stage transition, the settle counter,
// the offset handshake and the control fields of the result.
// ----------------------------------------------------------------------------
module hsq_merge (
   input  logic                              restart,
   input  hsq_pkg::seq_state_type            cur,
   input  hsq_pkg::lane_flags_type           all_set,
   input  logic [hsq_pkg::SW_W-1:0]          clear_mask,
   input  logic                              offset_done,
   input  logic [hsq_pkg::SETTLE_W-1:0]      settle_ticks,
   output hsq_pkg::seq_state_type            nxt,
   output hsq_pkg::out_ctrl_type             ctrl
);
   import hsq_pkg::*;

   logic [SETTLE_W-1:0] settle_inc;

   always_comb begin
      settle_inc = (cur.settle_count == '1) ? cur.settle_count
                                            : cur.settle_count + 1'b1;
      nxt  = cur;
      ctrl = '0;
      if (restart) begin
         nxt.stage          = ST_IDLE;
         nxt.settle_count   = '0;
         nxt.offset_pending = 1'b0;
      end else begin
         ctrl.phase = cur.stage;
         case (cur.stage)
            ST_IDLE: begin
               nxt.stage           = ST_COARSE;
               nxt.settle_count    = '0;
               nxt.offset_pending  = 1'b0;
               ctrl.clear_encoders = '1;
               ctrl.enable_motors  = 1'b1;
            end
            ST_COARSE: begin
               ctrl.drive_valid    = 1'b1;
               ctrl.clear_encoders = clear_mask;
               if (all_set.coarse_found) begin
                  nxt.settle_count = '0;
                  nxt.stage        = ST_BACKOFF;
               end
            end
            ST_BACKOFF: begin
               ctrl.drive_valid    = 1'b1;
               ctrl.clear_encoders = clear_mask;
               if (all_set.at_backoff) begin
                  nxt.settle_count = settle_inc;
                  if (settle_inc > settle_ticks) begin
                     if (!cur.offset_pending) begin
                        nxt.offset_pending  = 1'b1;
                        ctrl.offset_request = 1'b1;
                     end else if (offset_done) begin
                        nxt.offset_pending = 1'b0;
                        nxt.settle_count   = '0;
                        nxt.stage          = ST_FINE;
                     end
                  end
               end
            end
            ST_FINE: begin
               ctrl.drive_valid    = 1'b1;
               ctrl.clear_encoders = clear_mask;
               if (all_set.fine_found) begin
                  nxt.stage = ST_DONE;
               end
            end
            default: begin
               ctrl.drive_valid   = 1'b1;
               ctrl.phase         = ST_DONE;
               ctrl.homed         = 1'b1;
               nxt.stage          = ST_IDLE;
               nxt.settle_count   = '0;
               nxt.offset_pending = 1'b0;
            end
         endcase
      end
   end

endmodule

FILE: sv/hsq_scale.sv
// ----------------------------------------------------------------------------
// Homing sequencer error scaler
// Three register stages for one axis: difference, product with the gear
// ratio, then the Q8.8 floor shift and saturation to 32 bits.
// ----------------------------------------------------------------------------
module hsq_scale #(
   parameter int ANGLE_WIDTH = hsq_pkg::ANGLE_WIDTH
) (
   input  logic                                clock,
   input  logic                                load_diff,
   input  logic                                load_prod,
   input  logic                                load_err,
   input  logic signed [((ANGLE_WIDTH > hsq_pkg::POS_W) ? ANGLE_WIDTH : hsq_pkg::POS_W):0]
                                               diff,
   input  logic [hsq_pkg::GEAR_W-1:0]          gear_ratio,
   output logic signed [hsq_pkg::ERR_W-1:0]    error
);
   import hsq_pkg::*;

   localparam int DW = ((ANGLE_WIDTH > POS_W) ? ANGLE_WIDTH : POS_W) + 1;
   localparam int PW = DW + GEAR_W + 1;
   localparam int SW = PW - GEAR_FRAC;

   logic signed [DW-1:0]    diff_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    prod_in;
   logic signed [SW-1:0]    shifted;
   logic signed [ERR_W-1:0] error_ff;
   logic signed [ERR_W-1:0] error_in;
   logic [SW-ERR_W:0]       upper;

   always_comb begin
      prod_in = diff_ff * $signed({1'b0, gear_ratio});
      shifted = prod_ff[PW-1:GEAR_FRAC];
      upper   = shifted[SW-1:ERR_W-1];
      if ((upper == '0) || (upper == '1)) begin
         error_in = shifted[ERR_W-1:0];
      end else if (shifted[SW-1]) begin
         error_in = {1'b1, {(ERR_W-1){1'b0}}};
      end else begin
         error_in = {1'b0, {(ERR_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (load_diff) begin
         diff_ff <= diff;
      end
      if (load_prod) begin
         prod_ff <= prod_in;
      end
      if (load_err) begin
         error_ff <= error_in;
      end
   end

   assign error = error_ff;

endmodule

FILE: sv/three_axis_homing_sequencer.sv
// ----------------------------------------------------------------------------
// Three-axis homing sequencer
// Coarse search, backoff and settle, offset handshake, fine search and done,
// with gear-scaled position errors for every arm on each control tick.
// ----------------------------------------------------------------------------
// A result passes the difference, product and error registers after its request is accepted.
// Throughput: one request per cycle while the result channel does not hold back; the axis lanes and merge logic update
// the sequencer state in the accepting cycle, the gear multiply is pipelined.
// Reset: the stage returns to idle, targets and flags clear, the settle
// counter and offset handshake clear and the registers take their defaults.
module three_axis_homing_sequencer #(
   parameter int ANGLE_WIDTH = hsq_pkg::ANGLE_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   hsq_req_if.sink                            req_chan,
   hsq_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hsq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [hsq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [hsq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import hsq_pkg::*;

   localparam int DW = ((ANGLE_WIDTH > POS_W) ? ANGLE_WIDTH : POS_W) + 1;

   logic [STEP_W-1:0]   coarse_step_ff;
   logic [STEP_W-1:0]   fine_step_ff;
   logic [BOFF_W-1:0]   backoff_angle_ff;
   logic [TOL_W-1:0]    backoff_tol_ff;
   logic [SETTLE_W-1:0] settle_ticks_ff;
   logic [GEAR_W-1:0]   gear_ratio_ff;
   csr_reg_type         csr_index;
   logic                csr_write;

   seq_state_type               seq_ff;
   seq_state_type               seq_in;
   logic signed [ANGLE_WIDTH-1:0] target_ff [AXES];
   logic signed [ANGLE_WIDTH-1:0] target_in [AXES];
   lane_flags_type              flags_ff  [AXES];
   lane_flags_type              flags_in  [AXES];
   logic signed [DW-1:0]        lane_diff [AXES];
   logic signed [ERR_W-1:0]     lane_err  [AXES];
   logic signed [POS_W-1:0]     lane_pos  [AXES];
   logic [SW_W-1:0]             clear_mask;
   lane_flags_type              all_set;
   stage_type                   lane_stage;
   out_ctrl_type                ctrl;
   out_ctrl_type                ctrl1_ff;
   out_ctrl_type                ctrl2_ff;
   out_ctrl_type                ctrl3_ff;
   logic                        v1_ff;
   logic                        v2_ff;
   logic                        v3_ff;
   logic                        adv1;
   logic                        adv2;
   logic                        adv3;
   logic                        accept;

   // Configuration port.
   assign csr_index  = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_step_ff   <= COARSE_STEP_RST;
         fine_step_ff     <= FINE_STEP_RST;
         backoff_angle_ff <= BACKOFF_ANGLE_RST;
         backoff_tol_ff   <= BACKOFF_TOL_RST;
         settle_ticks_ff  <= SETTLE_TICKS_RST;
         gear_ratio_ff    <= GEAR_RATIO_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_COARSE_STEP:   coarse_step_ff   <= csr_pwdata[STEP_W-1:0];
            REG_FINE_STEP:     fine_step_ff     <= csr_pwdata[STEP_W-1:0];
            REG_BACKOFF_ANGLE: backoff_angle_ff <= csr_pwdata[BOFF_W-1:0];
            REG_BACKOFF_TOL:   backoff_tol_ff   <= csr_pwdata[TOL_W-1:0];
            REG_SETTLE_TICKS:  settle_ticks_ff  <= csr_pwdata[SETTLE_W-1:0];
            REG_GEAR_RATIO:    gear_ratio_ff    <= csr_pwdata[GEAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_COARSE_STEP:   csr_prdata = CSR_DATA_W'(coarse_step_ff);
         REG_FINE_STEP:     csr_prdata = CSR_DATA_W'(fine_step_ff);
         REG_BACKOFF_ANGLE: csr_prdata = CSR_DATA_W'(backoff_angle_ff);
         REG_BACKOFF_TOL:   csr_prdata = CSR_DATA_W'(backoff_tol_ff);
         REG_SETTLE_TICKS:  csr_prdata = CSR_DATA_W'(settle_ticks_ff);
         REG_GEAR_RATIO:    csr_prdata = CSR_DATA_W'(gear_ratio_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Pipeline flow control.
   assign adv3           = !v3_ff || rsp_chan.ready;
   assign adv2           = !v2_ff || adv3;
   assign adv1           = !v1_ff || adv2;
   assign req_chan.ready = adv1;
   assign accept         = req_chan.valid && adv1;

   assign lane_pos[0] = req_chan.position_a;
   assign lane_pos[1] = req_chan.position_b;
   assign lane_pos[2] = req_chan.position_c;
   assign lane_stage  = req_chan.restart ? ST_IDLE : seq_ff.stage;

   for (genvar i = 0; i < AXES; i++) begin : g_lane
      hsq_lane #(
         .ANGLE_WIDTH (ANGLE_WIDTH)
      ) u_lane (
         .stage             (lane_stage),
         .target            (target_ff[i]),
         .flags             (flags_ff[i]),
         .position          (lane_pos[i]),
         .home_switch       (req_chan.home_switches[i]),
         .coarse_step       (coarse_step_ff),
         .fine_step         (fine_step_ff),
         .backoff_angle     (backoff_angle_ff),
         .backoff_tolerance (backoff_tol_ff),
         .target_in         (target_in[i]),
         .flags_in          (flags_in[i]),
         .clear_encoder     (clear_mask[i]),
         .diff              (lane_diff[i])
      );

      hsq_scale #(
         .ANGLE_WIDTH (ANGLE_WIDTH)
      ) u_scale (
         .clock      (clock),
         .load_diff  (adv1),
         .load_prod  (adv2),
         .load_err   (adv3),
         .diff       (lane_diff[i]),
         .gear_ratio (gear_ratio_ff),
         .error      (lane_err[i])
      );
   end

   always_comb begin
      all_set = '1;
      for (int i = 0; i < AXES; i++) begin
         all_set = all_set & flags_in[i];
      end
   end

   hsq_merge u_merge (
      .restart      (req_chan.restart),
      .cur          (seq_ff),
      .all_set      (all_set),
      .clear_mask   (clear_mask),
      .offset_done  (req_chan.offset_done),
      .settle_ticks (settle_ticks_ff),
      .nxt          (seq_in),
      .ctrl         (ctrl)
   );

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff.stage          <= ST_IDLE;
         seq_ff.settle_count   <= '0;
         seq_ff.offset_pending <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            target_ff[i] <= '0;
            flags_ff[i]  <= '0;
         end
      end else if (accept) begin
         seq_ff <= seq_in;
         for (int i = 0; i < AXES; i++) begin
            target_ff[i] <= target_in[i];
            flags_ff[i]  <= flags_in[i];
         end
      end
   end

   // Result pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_chan.valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         ctrl1_ff <= ctrl;
      end
      if (adv2) begin
         ctrl2_ff <= ctrl1_ff;
      end
      if (adv3) begin
         ctrl3_ff <= ctrl2_ff;
      end
   end

   assign rsp_chan.valid          = v3_ff;
   assign rsp_chan.error_a        = lane_err[0];
   assign rsp_chan.error_b        = lane_err[1];
   assign rsp_chan.error_c        = lane_err[2];
   assign rsp_chan.drive_valid    = ctrl3_ff.drive_valid;
   assign rsp_chan.clear_encoders = ctrl3_ff.clear_encoders;
   assign rsp_chan.enable_motors  = ctrl3_ff.enable_motors;
   assign rsp_chan.offset_request = ctrl3_ff.offset_request;
   assign rsp_chan.phase          = ctrl3_ff.phase;
   assign rsp_chan.homed          = ctrl3_ff.homed;

   // Checks.
   a_settle_only_in_backoff: assert property (@(posedge clock) disable iff (reset)
      (seq_ff.settle_count != '0) |-> (seq_ff.stage == ST_BACKOFF))
      else $error("settle counter running outside the backoff stage");

   a_pending_only_in_backoff: assert property (@(posedge clock) disable iff (reset)
      seq_ff.offset_pending |-> (seq_ff.stage == ST_BACKOFF))
      else $error("offset request pending outside the backoff stage");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (seq_ff.stage == ST_DONE)) |=> (seq_ff.stage == ST_IDLE))
      else $error("finishing tick did not return the sequencer to idle");

   a_homed_in_done_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.homed) |->
         (rsp_chan.phase == ST_DONE) && rsp_chan.drive_valid)
      else $error("homed result outside the done phase");

endmodule
